>>> design/rcfw_pkg.sv
package rcfw_pkg;

    // Width of the output field in characters.
    localparam int OUT_WIDTH = 7;
    // The accumulator holds four bits per output character.
    localparam int ACC_W     = 4 * OUT_WIDTH;
    // Index into the output field; also counts the 4-bit divider groups.
    localparam int IDX_W     = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int CHAR_W    = 8;
    localparam int BASE_W    = 5;
    localparam int DIGIT_W   = 4;
    localparam int PROD_W    = ACC_W + BASE_W;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CHAR_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_O     = 8'h4F;

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

    // Digit code returned for a character that is not a hex digit.
    localparam logic [BASE_W-1:0] BAD_DIGIT = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;       // an input transaction completes
        logic             div_step;     // run one 4-bit group of the divider
        logic             first_group;  // first group of a digit: remainder starts at zero
        logic             last_group;   // last group of a digit: store the digit
        logic             first_digit;  // least significant output digit
        logic             last_digit;   // final division: check for leftover quotient
        logic [IDX_W-1:0] out_idx;      // field position being presented
    } dp_cmd_t;

    function automatic logic [BASE_W-1:0] char_to_digit(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0] d;
        d = BAD_DIGIT;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            d = BASE_W'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_A && c <= CHAR_F)
        begin
            d = BASE_W'(c - CHAR_A) + 5'd10;
        end
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d) - 8'd10;
        end
        return c;
    endfunction

    // Character of the right-justified ERROR text at field position j.
    function automatic logic [CHAR_W-1:0] err_char(input logic [IDX_W-1:0] j);
        int p;
        logic [CHAR_W-1:0] c;
        p = int'(j) + 5 - OUT_WIDTH;
        c = CHAR_SPACE;
        if (p >= 0)
        begin
            case (p)
                0:       c = CHAR_E;
                1:       c = CHAR_R;
                2:       c = CHAR_R;
                3:       c = CHAR_O;
                default: c = CHAR_R;
            endcase
        end
        return c;
    endfunction

endpackage

>>> design/rcfw_ctrl.sv
module rcfw_ctrl
    import rcfw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    last,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output logic    out_last,
    output dp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] grp_reg, grp_next;
    logic [IDX_W-1:0] dig_reg, dig_next;
    logic [IDX_W-1:0] oidx_reg, oidx_next;

    logic grp_end, dig_end, oidx_end;

    assign grp_end  = (grp_reg == IDX_W'(OUT_WIDTH - 1));
    assign dig_end  = (dig_reg == IDX_W'(OUT_WIDTH - 1));
    assign oidx_end = (oidx_reg == IDX_W'(OUT_WIDTH - 1));

    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        dig_next   = dig_reg;
        oidx_next  = oidx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        cmd.out_idx     = oidx_reg;
        cmd.first_group = (grp_reg == '0);
        cmd.last_group  = grp_end;
        cmd.first_digit = (dig_reg == '0);
        cmd.last_digit  = dig_end;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && last)
                begin
                    state_next = S_DIV;
                    grp_next   = '0;
                    dig_next   = '0;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (grp_end)
                begin
                    grp_next = '0;
                    dig_next = dig_reg + 1'b1;
                    if (dig_end)
                    begin
                        state_next = S_OUT;
                        oidx_next  = '0;
                    end
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 1'b1;
                    if (oidx_end)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_last = oidx_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grp_reg   <= '0;
            dig_reg   <= '0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            dig_reg   <= dig_next;
            oidx_reg  <= oidx_next;
        end
    end

endmodule

>>> design/rcfw_dp.sv
module rcfw_dp
    import rcfw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [CHAR_W-1:0] digit_char,
    input  logic [BASE_W-1:0] from_base,
    input  logic [BASE_W-1:0] to_base,
    input  logic              last,
    output logic [CHAR_W-1:0] out_char
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              sticky_reg, sticky_next;
    logic [ACC_W-1:0]  quo_reg, quo_next;
    logic [BASE_W-1:0] rem_reg, rem_next;
    logic [BASE_W-1:0] tb_reg;
    logic              err_reg;
    logic [CHAR_W-1:0] field_reg [OUT_WIDTH];

    logic [BASE_W-1:0] dig;
    logic              dig_ok;
    logic [PROD_W-1:0] mac;
    logic              tb_bad;
    logic [CHAR_W-1:0] new_char;

    // Multiply-add of one incoming digit.
    always_comb
    begin
        dig    = char_to_digit(digit_char);
        dig_ok = (dig != BAD_DIGIT) && (from_base >= BASE_MIN) && (from_base <= BASE_MAX)
                 && (dig < from_base);
        mac    = PROD_W'(acc_reg) * PROD_W'(from_base) + PROD_W'(dig);
        acc_next    = acc_reg;
        sticky_next = sticky_reg;
        if (!dig_ok)
        begin
            sticky_next = 1'b1;
        end
        else
        begin
            acc_next = mac[ACC_W-1:0];
            if (mac[PROD_W-1:ACC_W] != '0)
            begin
                sticky_next = 1'b1;
            end
        end
        tb_bad = (to_base < BASE_MIN) || (to_base > BASE_MAX);
    end

    // Four restoring division steps per cycle, quotient bits shift into quo.
    always_comb
    begin
        rem_next = cmd.first_group ? '0 : rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < 4; i++)
        begin
            rem_next = {rem_next[BASE_W-2:0], quo_next[ACC_W-1]};
            quo_next = {quo_next[ACC_W-2:0], 1'b0};
            if (rem_next >= tb_reg)
            begin
                rem_next    = rem_next - tb_reg;
                quo_next[0] = 1'b1;
            end
        end
        // Leading zeros are blanked; the least significant digit always shows.
        if (cmd.first_digit || (quo_next != '0) || (rem_next != '0))
        begin
            new_char = digit_to_char(rem_next[DIGIT_W-1:0]);
        end
        else
        begin
            new_char = CHAR_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            sticky_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (last)
            begin
                acc_reg    <= '0;
                sticky_reg <= 1'b0;
            end
            else
            begin
                acc_reg    <= acc_next;
                sticky_reg <= sticky_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && last)
        begin
            quo_reg <= acc_next;
            tb_reg  <= to_base;
            err_reg <= sticky_next || tb_bad;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            if (cmd.last_group)
            begin
                field_reg[0] <= new_char;
                for (int i = 1; i < OUT_WIDTH; i++)
                begin
                    field_reg[i] <= field_reg[i-1];
                end
                if (cmd.last_digit && (quo_next != '0))
                begin
                    err_reg <= 1'b1;
                end
            end
        end
    end

    assign out_char = err_reg ? err_char(cmd.out_idx) : field_reg[cmd.out_idx];

endmodule

>>> design/radix_converter_fixed_width.sv
// A digit without the last mark is added into the accumulator; after the last digit the
// converter divides (seven digits of seven 4-bit divider groups each)
// and then presents seven characters, one per output transaction.
// The block stays ready after a non-final digit and takes no input while converting.
// Reset: rst_n clears the controller, the accumulator and the sticky error flag.
module radix_converter_fixed_width
    import rcfw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] digit_char,
    input  logic [BASE_W-1:0] from_base,
    input  logic [BASE_W-1:0] to_base,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    // The controller sequences acceptance, the iterative divider and the output
    // field; the datapath holds the accumulator, the divider and the character field.
    dp_cmd_t cmd;

    rcfw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (out_last),
        .cmd       (cmd)
    );

    // The datapath accumulates each accepted digit with one multiply-add, then
    // peels target-base digits off by repeated division, least significant first.
    // A quotient left over after the final division means the value does not fit.
    rcfw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .digit_char (digit_char),
        .from_base  (from_base),
        .to_base    (to_base),
        .last       (last),
        .out_char   (out_char)
    );

    // Input and output sides are never open at the same time.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output both open");

    // A final digit starts the conversion: no transaction on either side next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> (!in_ready && !out_valid))
        else $error("conversion did not start after final digit");

    // A digit that is not final leaves the block ready for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last) |=> in_ready)
        else $error("block stalled after a non-final digit");

    // After the final character goes out, the block takes input again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
        else $error("block did not return to input after final character");

endmodule
